// File: hw/rtl/lzwd_pkg.sv
package lzwd_pkg;

  localparam int MAX_CODE_BITS_DEF  = 12;
  localparam int TABLE_DEPTH_DEF    = 3840;
  localparam int MAX_STRING_LEN_DEF = 3841;

  localparam int LITERALS      = 256;
  localparam int MIN_CODE_BITS = 9;
  localparam int CHUNK_BYTES   = 64;

  localparam int VALUE_W     = 12;
  localparam int WORD_W      = 64;
  localparam int COUNT_W     = 7;
  localparam int CODE_BITS_W = 4;
  localparam int OUT_LEN_W   = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CODE_BITS_W-1:0] CODE_BITS_RESET  = 4'd12;
  localparam logic [OUT_LEN_W-1:0]   OUT_LENGTH_RESET = 32'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CODE_BITS  = 1'b0,
    REG_OUT_LENGTH = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_CODE  = 1'b1
  } item_kind_t;

endpackage

// File: hw/rtl/lzwd_in_if.sv
interface lzwd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [lzwd_pkg::VALUE_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

// File: hw/rtl/lzwd_out_if.sv
interface lzwd_out_if;
  logic                         valid;
  logic                         ready;
  logic [lzwd_pkg::WORD_W-1:0]  bytes_0_7;
  logic [lzwd_pkg::WORD_W-1:0]  bytes_8_15;
  logic [lzwd_pkg::WORD_W-1:0]  bytes_16_23;
  logic [lzwd_pkg::WORD_W-1:0]  bytes_24_31;
  logic [lzwd_pkg::WORD_W-1:0]  bytes_32_39;
  logic [lzwd_pkg::WORD_W-1:0]  bytes_40_47;
  logic [lzwd_pkg::WORD_W-1:0]  bytes_48_55;
  logic [lzwd_pkg::WORD_W-1:0]  bytes_56_63;
  logic [lzwd_pkg::COUNT_W-1:0] byte_count;
  logic                         last_chunk;
  logic                         stream_done;

  modport source (
    output valid, output bytes_0_7, output bytes_8_15, output bytes_16_23,
    output bytes_24_31, output bytes_32_39, output bytes_40_47, output bytes_48_55,
    output bytes_56_63, output byte_count, output last_chunk, output stream_done,
    input ready
  );
  modport sink (
    input valid, input bytes_0_7, input bytes_8_15, input bytes_16_23,
    input bytes_24_31, input bytes_32_39, input bytes_40_47, input bytes_48_55,
    input bytes_56_63, input byte_count, input last_chunk, input stream_done,
    output ready
  );
endinterface

// File: hw/rtl/lzwd_cfg_if.sv
interface lzwd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lzwd_pkg::CFG_IDX_W-1:0]  index;
  logic [lzwd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/lzwd_ram.sv
module lzwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/lzw_code_decoder_core.sv
// when the table is full, the previous string is first walked into the carry
//   buffer before the code is decoded
// throughput: one item at a time; the prefix chain walk (one table read per
//   cycle) and the stack read-out (one byte per cycle, paused while a
//   finished chunk waits for the output register) set the pace
// reset: rst clears control state, decoder state and the configuration registers; memories are not cleared
module lzw_code_decoder_core #(
  parameter int MAX_CODE_BITS  = lzwd_pkg::MAX_CODE_BITS_DEF,
  parameter int TABLE_DEPTH    = lzwd_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_STRING_LEN = lzwd_pkg::MAX_STRING_LEN_DEF
) (
  input logic         clk,
  input logic         rst,
  lzwd_in_if.sink     code_in,
  lzwd_out_if.source  chunk_out,
  lzwd_cfg_if.sink    cfg
);

  // widths derived from the table and string limits
  localparam int LIT       = lzwd_pkg::LITERALS;
  localparam int REF_W     = $clog2(LIT + TABLE_DEPTH + 1);
  localparam int LEN_W     = $clog2(MAX_STRING_LEN + 1);
  localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int TBL_AW    = $clog2(TABLE_DEPTH);
  localparam int CAR_DEPTH = MAX_STRING_LEN - 1;
  localparam int CAR_AW    = $clog2(CAR_DEPTH);
  localparam int STK_AW    = $clog2(MAX_STRING_LEN);
  localparam int POW_W     = MAX_CODE_BITS + 1;
  localparam int VAL_W     = lzwd_pkg::VALUE_W;
  localparam int CB_W      = lzwd_pkg::CODE_BITS_W;
  localparam int NBYTES    = lzwd_pkg::CHUNK_BYTES;
  localparam int CH_AW     = $clog2(NBYTES);
  localparam int CW        = lzwd_pkg::COUNT_W;
  localparam int OL_W      = lzwd_pkg::OUT_LEN_W;
  localparam int WW        = lzwd_pkg::WORD_W;

  localparam logic [REF_W-1:0] CARRY_REF = REF_W'(LIT + TABLE_DEPTH);
  localparam logic [REF_W-1:0] LIT_REF   = REF_W'(LIT);
  localparam logic [VAL_W-1:0] LIT_VAL   = VAL_W'(LIT);
  localparam logic [LEN_W-1:0] MAX_LEN   = LEN_W'(MAX_STRING_LEN);
  localparam logic [LEN_W-1:0] CAR_MAX   = LEN_W'(CAR_DEPTH);

  // table entry: prefix reference, last byte, first byte, length
  typedef struct packed {
    logic [REF_W-1:0] prefix;
    logic [7:0]       last;
    logic [7:0]       first;
    logic [LEN_W-1:0] len;
  } tbl_entry_t;

  localparam int TBL_W = $bits(tbl_entry_t);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,  // waiting for an item
    S_DEC   = 8'b0000_0010,  // table read of the code's entry
    S_LOOK  = 8'b0000_0100,  // classify code, append entry
    S_COPY  = 8'b0000_1000,  // append as copy of an over-long previous entry
    S_START = 8'b0001_0000,  // current string becomes previous, start walk
    S_WALK  = 8'b0010_0000,  // prefix chain walk, one entry per cycle
    S_KSET  = 8'b0100_0000,  // truncate at out_length, prepare chunk
    S_EMIT  = 8'b1000_0000   // read string forward into chunks
  } state_t;

  state_t state;

  // configuration registers
  logic [CB_W-1:0] code_bits;
  logic [OL_W-1:0] out_length;

  // decoder state
  logic [CNT_W-1:0] entry_count;
  logic [REF_W-1:0] prev_ref;
  logic [7:0]       prev_first;
  logic [LEN_W-1:0] prev_len;
  logic [LEN_W-1:0] carry_len;
  logic [OL_W-1:0]  bytes_emitted;

  // current code
  logic [VAL_W-1:0] code;
  logic [REF_W-1:0] cur_ref;
  logic [7:0]       cur_first;
  logic [LEN_W-1:0] cur_len;
  logic             cur_unknown;

  // chain walker
  logic [REF_W-1:0] walk_r;
  logic [LEN_W-1:0] walk_pos;
  logic             walk_pend;
  logic             walk_clear;
  logic [LEN_W-1:0] walk_n;
  logic [LEN_W-1:0] base_len;

  // forward read-out
  logic [LEN_W-1:0] emit_k;
  logic [LEN_W-1:0] rd_idx;
  logic             rp_valid;
  logic             rp_end;
  logic [CH_AW-1:0] rp_pos;
  logic             rp_carry;
  logic [7:0]       chunk [NBYTES];
  logic [CW-1:0]    chunk_cnt;
  logic             chunk_rdy;

  // output register
  logic                  out_valid;
  logic [8*NBYTES-1:0]   out_bytes;
  logic [CW-1:0]         out_cnt;
  logic                  out_last;
  logic                  out_done;

  // memory ports
  logic              tbl_we;
  logic [TBL_AW-1:0] tbl_waddr;
  tbl_entry_t        tbl_wdata;
  logic [TBL_AW-1:0] tbl_raddr;
  logic [TBL_W-1:0]  tbl_rdata;
  tbl_entry_t        tbl_q;

  logic              stk_we;
  logic [STK_AW-1:0] stk_waddr;
  logic [7:0]        stk_wdata;
  logic [7:0]        stk_q;

  logic              car_we;
  logic [CAR_AW-1:0] car_waddr;
  logic [7:0]        car_q;

  assign tbl_q = tbl_entry_t'(tbl_rdata);

  // code width clamp and table capacity
  logic [CB_W-1:0]  cb;
  logic [POW_W-1:0] pow;
  logic [POW_W-1:0] cap;
  logic             need_clear;
  logic [VAL_W-1:0] code_masked;

  always_comb begin
    if (32'(code_bits) < 32'(lzwd_pkg::MIN_CODE_BITS)) begin
      cb = CB_W'(lzwd_pkg::MIN_CODE_BITS);
    end else if (32'(code_bits) > 32'(MAX_CODE_BITS)) begin
      cb = CB_W'(MAX_CODE_BITS);
    end else begin
      cb = code_bits;
    end
    pow = POW_W'(1) << cb;
    cap = pow - POW_W'(LIT);
    if (32'(cap) > 32'(TABLE_DEPTH)) begin
      cap = POW_W'(TABLE_DEPTH);
    end
    need_clear  = 32'(entry_count) >= 32'(cap);
    code_masked = code_in.value & VAL_W'(pow - POW_W'(1));
  end

  // code classification
  logic             code_lit;
  logic [VAL_W-1:0] code_off;
  logic             code_known;
  logic             copy_case;
  logic [LEN_W-1:0] new_len;

  always_comb begin
    code_lit   = code < LIT_VAL;
    code_off   = code - LIT_VAL;
    code_known = !code_lit && (32'(code_off) < 32'(entry_count));
    copy_case  = (prev_len >= MAX_LEN) && (prev_ref >= LIT_REF) && (prev_ref < CARRY_REF);
    new_len    = (prev_len >= MAX_LEN) ? MAX_LEN : prev_len + LEN_W'(1);
  end

  // walker step: land a pending entry, then look at the next reference
  logic             land;
  logic [LEN_W-1:0] pos_a;
  logic [REF_W-1:0] r_a;
  logic             a_entry;
  logic             a_carry;
  logic             walk_wr;
  logic [LEN_W-1:0] walk_wpos;
  logic [7:0]       walk_wbyte;

  always_comb begin
    land    = walk_pend;
    pos_a   = land ? walk_pos - LEN_W'(1) : walk_pos;
    r_a     = land ? tbl_q.prefix : walk_r;
    a_entry = (r_a >= LIT_REF) && (r_a < CARRY_REF);
    a_carry = r_a == CARRY_REF;
    walk_wr    = 1'b0;
    walk_wpos  = walk_pos - LEN_W'(1);
    walk_wbyte = tbl_q.last;
    if (state == S_WALK) begin
      if (land) begin
        walk_wr = 1'b1;
      end else if (walk_pos != '0 && walk_r < LIT_REF) begin
        walk_wr    = 1'b1;
        walk_wbyte = walk_r[7:0];
      end
    end
  end

  // forward read-out control
  logic             in_fire;
  logic             rd_issue;
  logic             rd_end;
  logic [7:0]       land_byte;
  logic             flush;
  logic [OL_W-1:0]  be_sum;
  logic [OL_W-1:0]  room;

  always_comb begin
    in_fire   = code_in.valid && code_in.ready;
    rd_issue  = (state == S_EMIT) && (rd_idx < emit_k) && !chunk_rdy && !(rp_valid && rp_end);
    rd_end    = (rd_idx[CH_AW-1:0] == '1) || (rd_idx == emit_k - LEN_W'(1));
    land_byte = rp_carry ? car_q : stk_q;
    flush     = (state == S_EMIT) && chunk_rdy && (!out_valid || chunk_out.ready);
    be_sum    = bytes_emitted + OL_W'(chunk_cnt);
    room      = (out_length > bytes_emitted) ? out_length - bytes_emitted : '0;
  end

  // memory port muxing
  always_comb begin
    tbl_raddr = '0;
    case (state)
      S_DEC:   tbl_raddr = TBL_AW'(code_off);
      S_LOOK:  tbl_raddr = TBL_AW'(prev_ref - LIT_REF);
      S_WALK:  tbl_raddr = TBL_AW'(r_a - LIT_REF);
      default: tbl_raddr = '0;
    endcase

    tbl_we    = ((state == S_LOOK) && !copy_case) || (state == S_COPY);
    tbl_waddr = entry_count[TBL_AW-1:0];
    if (state == S_COPY) begin
      tbl_wdata = tbl_q;
    end else begin
      tbl_wdata.prefix = prev_ref;
      tbl_wdata.first  = prev_first;
      tbl_wdata.len    = new_len;
      if (code_lit) begin
        tbl_wdata.last = code[7:0];
      end else if (code_known) begin
        tbl_wdata.last = tbl_q.first;
      end else begin
        tbl_wdata.last = prev_first;
      end
    end

    // stack takes the start byte or the walked string
    stk_we    = 1'b0;
    stk_waddr = walk_wpos[STK_AW-1:0];
    stk_wdata = walk_wbyte;
    if (state == S_IDLE && in_fire && code_in.kind == lzwd_pkg::KIND_START) begin
      stk_we    = 1'b1;
      stk_waddr = '0;
      stk_wdata = code_in.value[7:0];
    end else if (walk_wr && !walk_clear) begin
      stk_we = 1'b1;
    end

    // carry buffer keeps at most its depth; the carried part is already in place
    car_we    = walk_wr && walk_clear && (walk_wpos < CAR_MAX);
    car_waddr = walk_wpos[CAR_AW-1:0];
  end

  lzwd_ram #(.WIDTH(TBL_W), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  lzwd_ram #(.WIDTH(8), .DEPTH(MAX_STRING_LEN)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (rd_idx[STK_AW-1:0]),
    .rdata (stk_q)
  );

  lzwd_ram #(.WIDTH(8), .DEPTH(CAR_DEPTH)) u_carry (
    .clk   (clk),
    .we    (car_we),
    .waddr (car_waddr),
    .wdata (walk_wbyte),
    .raddr (rd_idx[CAR_AW-1:0]),
    .rdata (car_q)
  );

  // configuration writes, always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_bits  <= lzwd_pkg::CODE_BITS_RESET;
      out_length <= lzwd_pkg::OUT_LENGTH_RESET;
    end else if (cfg.valid) begin
      case (lzwd_pkg::cfg_reg_t'(cfg.index))
        lzwd_pkg::REG_CODE_BITS:  code_bits  <= cfg.data[CB_W-1:0];
        lzwd_pkg::REG_OUT_LENGTH: out_length <= cfg.data[OL_W-1:0];
        default: ;
      endcase
    end
  end

  assign code_in.ready = (state == S_IDLE);

  // output register holds a chunk until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= flush || (out_valid && !chunk_out.ready);
    end
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      entry_count   <= '0;
      prev_ref      <= '0;
      prev_first    <= '0;
      prev_len      <= '0;
      carry_len     <= '0;
      bytes_emitted <= '0;
      walk_pend     <= 1'b0;
      walk_clear    <= 1'b0;
      rp_valid      <= 1'b0;
      chunk_rdy     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (code_in.kind == lzwd_pkg::KIND_START) begin
              entry_count   <= '0;
              prev_ref      <= REF_W'(code_in.value[7:0]);
              prev_first    <= code_in.value[7:0];
              prev_len      <= LEN_W'(1);
              bytes_emitted <= '0;
              base_len      <= '0;
              walk_n        <= LEN_W'(1);
              state         <= S_KSET;
            end else if (prev_len != '0) begin
              code <= code_masked;
              if (need_clear) begin
                // table full: previous string goes into the carry buffer
                walk_r     <= prev_ref;
                walk_pos   <= prev_len;
                walk_n     <= prev_len;
                walk_pend  <= 1'b0;
                walk_clear <= 1'b1;
                state      <= S_WALK;
              end else begin
                state <= S_DEC;
              end
            end
          end
        end

        S_DEC: begin
          state <= S_LOOK;
        end

        S_LOOK: begin
          cur_unknown <= !code_lit && !code_known;
          if (code_lit) begin
            cur_ref   <= REF_W'(code);
            cur_first <= code[7:0];
            cur_len   <= LEN_W'(1);
          end else if (code_known) begin
            cur_ref   <= REF_W'(code);
            cur_first <= tbl_q.first;
            cur_len   <= tbl_q.len;
          end else begin
            // code past the table end names the entry appended now
            cur_ref   <= LIT_REF + REF_W'(entry_count);
            cur_first <= prev_first;
            cur_len   <= new_len;
          end
          if (copy_case) begin
            state <= S_COPY;
          end else begin
            entry_count <= entry_count + CNT_W'(1);
            state       <= S_START;
          end
        end

        S_COPY: begin
          entry_count <= entry_count + CNT_W'(1);
          if (cur_unknown) begin
            cur_len <= tbl_q.len;
          end
          state <= S_START;
        end

        S_START: begin
          prev_ref   <= cur_ref;
          prev_first <= cur_first;
          prev_len   <= cur_len;
          walk_r     <= cur_ref;
          walk_pos   <= cur_len;
          walk_n     <= cur_len;
          walk_pend  <= 1'b0;
          walk_clear <= 1'b0;
          base_len   <= '0;
          state      <= S_WALK;
        end

        S_WALK: begin
          logic done;
          done = 1'b0;
          if (land) begin
            if (pos_a == '0) begin
              done = 1'b1;
            end else if (a_entry) begin
              walk_pos <= pos_a;
            end else if (a_carry) begin
              base_len <= pos_a;
              done = 1'b1;
            end else begin
              // literal at the chain's root, written next cycle
              walk_r    <= r_a;
              walk_pos  <= pos_a;
              walk_pend <= 1'b0;
            end
          end else begin
            if (walk_pos == '0 || walk_r < LIT_REF) begin
              done = 1'b1;
            end else if (a_carry) begin
              base_len <= walk_pos;
              done = 1'b1;
            end else if (a_entry) begin
              walk_pend <= 1'b1;
            end else begin
              done = 1'b1;
            end
          end
          if (done) begin
            walk_pend <= 1'b0;
            if (walk_clear) begin
              carry_len   <= (walk_n > CAR_MAX) ? CAR_MAX : walk_n;
              prev_len    <= (walk_n > CAR_MAX) ? CAR_MAX : walk_n;
              prev_ref    <= CARRY_REF;
              entry_count <= '0;
              walk_clear  <= 1'b0;
              state       <= S_DEC;
            end else begin
              state <= S_KSET;
            end
          end
        end

        S_KSET: begin
          emit_k    <= (32'(walk_n) < 32'(room)) ? walk_n : LEN_W'(room);
          rd_idx    <= '0;
          rp_valid  <= 1'b0;
          chunk_cnt <= '0;
          for (int i = 0; i < NBYTES; i++) begin
            chunk[i] <= '0;
          end
          // nothing left to give: a single empty chunk
          chunk_rdy <= (out_length <= bytes_emitted) || (walk_n == '0);
          state     <= S_EMIT;
        end

        S_EMIT: begin
          rp_valid <= rd_issue;
          if (rd_issue) begin
            rp_end   <= rd_end;
            rp_pos   <= rd_idx[CH_AW-1:0];
            rp_carry <= rd_idx < base_len;
            rd_idx   <= rd_idx + LEN_W'(1);
          end
          if (rp_valid) begin
            chunk[rp_pos] <= land_byte;
            chunk_cnt     <= chunk_cnt + CW'(1);
            if (rp_end) begin
              chunk_rdy <= 1'b1;
            end
          end
          if (flush) begin
            out_cnt       <= chunk_cnt;
            out_last      <= rd_idx == emit_k;
            out_done      <= be_sum >= out_length;
            bytes_emitted <= be_sum;
            for (int i = 0; i < NBYTES; i++) begin
              out_bytes[8*i +: 8] <= chunk[i];
              chunk[i]            <= '0;
            end
            chunk_cnt <= '0;
            chunk_rdy <= 1'b0;
            if (rd_idx == emit_k) begin
              state <= S_IDLE;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // result transfer
  assign chunk_out.valid       = out_valid;
  assign chunk_out.bytes_0_7   = out_bytes[0*WW +: WW];
  assign chunk_out.bytes_8_15  = out_bytes[1*WW +: WW];
  assign chunk_out.bytes_16_23 = out_bytes[2*WW +: WW];
  assign chunk_out.bytes_24_31 = out_bytes[3*WW +: WW];
  assign chunk_out.bytes_32_39 = out_bytes[4*WW +: WW];
  assign chunk_out.bytes_40_47 = out_bytes[5*WW +: WW];
  assign chunk_out.bytes_48_55 = out_bytes[6*WW +: WW];
  assign chunk_out.bytes_56_63 = out_bytes[7*WW +: WW];
  assign chunk_out.byte_count  = out_cnt;
  assign chunk_out.last_chunk  = out_last;
  assign chunk_out.stream_done = out_done;

  // a pending chain read always has a byte position left to fill
  a_walk_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && walk_pend) |-> (walk_pos != '0))
    else $error("chain walk ran past the string start");

  // appends never land beyond the table
  a_tbl_room: assert property (@(posedge clk) disable iff (rst)
    tbl_we |-> (32'(entry_count) < 32'(TABLE_DEPTH)))
    else $error("table append beyond depth");

  // a finished chunk waits with no read in flight
  a_chunk_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && chunk_rdy) |-> !rp_valid)
    else $error("read landed on a finished chunk");

endmodule
